// ===== hdl/network_ring_space_allocator_defines.svh =====
// Assertion helpers for the ring space allocator
`ifndef NETWORK_RING_SPACE_ALLOCATOR_DEFINES_SVH
`define NETWORK_RING_SPACE_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define NRSA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication, checked out of reset
`define NRSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ===== hdl/nrsa_pkg.sv =====
package nrsa_pkg;

  // Field widths
  localparam int unsigned OffW   = 17;
  localparam int unsigned MoveW  = 18;
  localparam int unsigned TotalW = 32;
  localparam int unsigned CalcW  = 20;

  // Largest ring the block will use, in bytes
  localparam int unsigned MaxBytes = 65536;
  localparam logic [24:0] MaxBytesVal = 25'(MaxBytes);

  // Ring size after reset
  localparam logic [OffW-1:0] ResetBufSize = 17'd65536;

  typedef logic signed [CalcW-1:0] nrsa_calc_t;

  typedef enum logic [1:0] {
    MODE_RESERVE   = 2'd0,
    MODE_RECV_MOVE = 2'd1,
    MODE_RELEASE   = 2'd2,
    MODE_GET_SEND  = 2'd3
  } nrsa_mode_e;

  // One request item
  typedef struct packed {
    logic [1:0]      mode;
    logic [MoveW-1:0] move_length;
    logic [OffW-1:0] max_recv_length;
    logic [OffW-1:0] bytes_received;
    logic [OffW-1:0] release_size;
    logic [OffW-1:0] request_size;
  } nrsa_item_t;

  // Ring bookkeeping
  typedef struct packed {
    logic [OffW-1:0]   wr_off;
    logic [OffW-1:0]   rd_off;
    logic [OffW-1:0]   wrap_mark;
    logic [OffW-1:0]   used;
    logic [TotalW-1:0] total;
  } nrsa_state_t;

  // One result item
  typedef struct packed {
    logic              granted;
    logic [OffW-1:0]   start_offset;
    logic [OffW-1:0]   send_length;
    logic              copy_valid;
    logic [OffW-1:0]   copy_from;
    logic [OffW-1:0]   copy_length;
    logic [OffW-1:0]   used_bytes;
    logic [TotalW-1:0] total_bytes;
    logic [OffW-1:0]   write_offset_now;
  } nrsa_result_t;

  // Written size to ring size: zero counts as one, capped at MaxBytes
  function automatic logic [OffW-1:0] ring_size(input logic [OffW-1:0] buf_size);
    logic [OffW-1:0] s;
    s = buf_size;
    if (buf_size == '0) begin
      s = 17'd1;
    end else if ({8'd0, buf_size} > MaxBytesVal) begin
      s = MaxBytesVal[OffW-1:0];
    end
    return s;
  endfunction

endpackage

// ===== hdl/nrsa_in_stage.sv =====
// Input register: holds the accepted item for evaluation
module nrsa_in_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  nrsa_pkg::nrsa_item_t item_i,
  output logic                valid_o,
  output nrsa_pkg::nrsa_item_t item_o
);

  logic                 valid_q;
  nrsa_pkg::nrsa_item_t item_q;

  // Valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= take_i;
    end
  end

  // Payload, loaded only on accept
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ===== hdl/nrsa_step.sv =====
// One request against the ring state: next state and the result item
module nrsa_step (
  input  nrsa_pkg::nrsa_item_t   item_i,
  input  nrsa_pkg::nrsa_state_t  state_i,
  input  logic [nrsa_pkg::OffW-1:0] size_i,
  output nrsa_pkg::nrsa_state_t  state_o,
  output nrsa_pkg::nrsa_result_t result_o
);

  nrsa_pkg::nrsa_calc_t m_s, r_s, b_s, rel_s, req_s;
  nrsa_pkg::nrsa_calc_t wo_s, used_s, size_s;
  nrsa_pkg::nrsa_calc_t end_s, room_s, used_m_s;
  nrsa_pkg::nrsa_calc_t wm_s, ro_s, want_s, avail_s, n_s;
  logic [nrsa_pkg::TotalW-1:0] m_ext;
  logic ok_base, wrap, ok;
  nrsa_pkg::nrsa_state_t  nxt;
  nrsa_pkg::nrsa_result_t res;

  always_comb begin
    // Operands widened to one signed width
    m_s    = nrsa_pkg::nrsa_calc_t'($signed({{2{item_i.move_length[17]}},
                                               item_i.move_length}));
    r_s    = $signed({3'd0, item_i.max_recv_length});
    b_s    = $signed({3'd0, item_i.bytes_received});
    rel_s  = $signed({3'd0, item_i.release_size});
    req_s  = $signed({3'd0, item_i.request_size});
    wo_s   = $signed({3'd0, state_i.wr_off});
    used_s = $signed({3'd0, state_i.used});
    size_s = $signed({3'd0, size_i});
    m_ext  = {{14{item_i.move_length[17]}}, item_i.move_length};

    end_s    = wo_s + m_s;
    room_s   = size_s - wo_s;
    used_m_s = used_s + m_s;

    // Receive-move checks
    ok_base = (used_m_s + r_s <= size_s) && !used_m_s[nrsa_pkg::CalcW-1]
              && !end_s[nrsa_pkg::CalcW-1];
    wrap    = ok_base && !(room_s >= m_s + r_s);
    ok      = ok_base && !(wrap && ((end_s > size_s) || (b_s > end_s)));

    // Send span: wrap the read side first when it reached the mark
    if (state_i.rd_off >= state_i.wrap_mark) begin
      wm_s = size_s;
      ro_s = '0;
    end else begin
      wm_s = $signed({3'd0, state_i.wrap_mark});
      ro_s = $signed({3'd0, state_i.rd_off});
    end
    want_s  = (used_s > req_s) ? req_s : used_s;
    avail_s = wm_s - ro_s;
    n_s     = (avail_s >= want_s) ? want_s : avail_s;

    nxt = state_i;
    res = '0;

    unique case (nrsa_pkg::nrsa_mode_e'(item_i.mode))
      nrsa_pkg::MODE_RESERVE: begin
        if (!m_s[nrsa_pkg::CalcW-1] && (used_m_s <= size_s)) begin
          if (room_s >= m_s) begin
            res.start_offset = state_i.wr_off;
            nxt.wr_off       = end_s[nrsa_pkg::OffW-1:0];
          end else begin
            nxt.wrap_mark    = state_i.wr_off;
            res.start_offset = '0;
            nxt.wr_off       = m_s[nrsa_pkg::OffW-1:0];
          end
          nxt.used    = used_m_s[nrsa_pkg::OffW-1:0];
          nxt.total   = state_i.total + m_ext;
          res.granted = 1'b1;
        end
      end
      nrsa_pkg::MODE_RECV_MOVE: begin
        if (ok) begin
          if (!wrap) begin
            nxt.wr_off = end_s[nrsa_pkg::OffW-1:0];
          end else begin
            // Partial packet moves to the front
            nxt.wrap_mark   = state_i.wr_off;
            res.copy_valid  = 1'b1;
            res.copy_from   = nrsa_pkg::OffW'(end_s - b_s);
            res.copy_length = item_i.bytes_received;
            nxt.wr_off      = item_i.bytes_received;
          end
          nxt.used         = used_m_s[nrsa_pkg::OffW-1:0];
          nxt.total        = state_i.total + m_ext;
          res.granted      = 1'b1;
          res.start_offset = nxt.wr_off;
        end
      end
      nrsa_pkg::MODE_RELEASE: begin
        // Saturates at zero
        nxt.used = (used_s > rel_s) ? nrsa_pkg::OffW'(used_s - rel_s) : '0;
      end
      nrsa_pkg::MODE_GET_SEND: begin
        nxt.wrap_mark = wm_s[nrsa_pkg::OffW-1:0];
        nxt.rd_off    = ro_s[nrsa_pkg::OffW-1:0];
        if (state_i.used != '0) begin
          res.granted      = 1'b1;
          res.start_offset = ro_s[nrsa_pkg::OffW-1:0];
          res.send_length  = n_s[nrsa_pkg::OffW-1:0];
          nxt.rd_off       = nrsa_pkg::OffW'(ro_s + n_s);
        end
      end
    endcase

    res.used_bytes       = nxt.used;
    res.total_bytes      = nxt.total;
    res.write_offset_now = nxt.wr_off;
  end

  assign state_o  = nxt;
  assign result_o = res;

endmodule

// ===== hdl/network_ring_space_allocator.sv =====
// Ring space allocator: one request in, one result out.
// An accepted item passes the input register, then the state and result register,
//   which drive the strobe and the result.
// Throughput: one item every cycle; busy stays low. The receiver cannot stall; each
//   result is shown for exactly one cycle.
// Reset (async, active low): ring size 65536, offsets, used and total zero, wrap mark
//   at ring size. A size write resets the ring state in the same way.
`include "network_ring_space_allocator_defines.svh"

module network_ring_space_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [17:0] move_length_i,
  input  logic [16:0] max_recv_length_i,
  input  logic [16:0] bytes_received_i,
  input  logic [16:0] release_size_i,
  input  logic [16:0] request_size_i,
  // Size register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [16:0] cfg_data_i,
  // Result channel
  output logic        done_o,
  output logic        granted_o,
  output logic [16:0] start_offset_o,
  output logic [16:0] send_length_o,
  output logic        copy_valid_o,
  output logic [16:0] copy_from_o,
  output logic [16:0] copy_length_o,
  output logic [16:0] used_bytes_o,
  output logic [31:0] total_bytes_o,
  output logic [16:0] write_offset_now_o
);

  nrsa_pkg::nrsa_item_t   item_in, item_stg;
  logic                   stg_valid;
  nrsa_pkg::nrsa_state_t  state_q, state_d;
  nrsa_pkg::nrsa_result_t res_d, res_q;
  logic [nrsa_pkg::OffW-1:0] size_q;
  logic                   done_q;
  logic                   cfg_wr;

  // Always able to take an item
  assign busy        = 1'b0;
  assign cfg_ready_o = !stg_valid;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  assign item_in.mode            = mode_i;
  assign item_in.move_length     = move_length_i;
  assign item_in.max_recv_length = max_recv_length_i;
  assign item_in.bytes_received  = bytes_received_i;
  assign item_in.release_size    = release_size_i;
  assign item_in.request_size    = request_size_i;

  nrsa_in_stage u_in_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .take_i  (start && !busy),
    .item_i  (item_in),
    .valid_o (stg_valid),
    .item_o  (item_stg)
  );

  nrsa_step u_step (
    .item_i   (item_stg),
    .state_i  (state_q),
    .size_i   (size_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Ring size and bookkeeping; a size write starts a fresh ring
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= nrsa_pkg::ring_size(nrsa_pkg::ResetBufSize);
      state_q <= '{wr_off: '0, rd_off: '0,
                   wrap_mark: nrsa_pkg::ring_size(nrsa_pkg::ResetBufSize),
                   used: '0, total: '0};
    end else if (cfg_wr) begin
      size_q  <= nrsa_pkg::ring_size(cfg_data_i);
      state_q <= '{wr_off: '0, rd_off: '0,
                   wrap_mark: nrsa_pkg::ring_size(cfg_data_i),
                   used: '0, total: '0};
    end else if (stg_valid) begin
      state_q <= state_d;
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= stg_valid;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (stg_valid) begin
      res_q <= res_d;
    end
  end

  assign done_o             = done_q;
  assign granted_o          = res_q.granted;
  assign start_offset_o     = res_q.start_offset;
  assign send_length_o      = res_q.send_length;
  assign copy_valid_o       = res_q.copy_valid;
  assign copy_from_o        = res_q.copy_from;
  assign copy_length_o      = res_q.copy_length;
  assign used_bytes_o       = res_q.used_bytes;
  assign total_bytes_o      = res_q.total_bytes;
  assign write_offset_now_o = res_q.write_offset_now;

  // Checks
  `NRSA_ASSERT_IMPLY(a_used_in_ring, clk_i, rst_ni, 1'b1, state_q.used <= size_q)
  `NRSA_ASSERT_NEXT(a_item_gives_result, clk_i, rst_ni, stg_valid, done_o)
  `NRSA_ASSERT_IMPLY(a_copy_sets_wr, clk_i, rst_ni, done_o && copy_valid_o,
                     granted_o && (copy_length_o == write_offset_now_o))
  `NRSA_ASSERT_IMPLY(a_refusal_clean, clk_i, rst_ni, done_o && !granted_o,
                     (start_offset_o == '0) && (send_length_o == '0) && !copy_valid_o)

endmodule

// ===== sim/nrsa_ring_checker.sv =====
// Checker for the ring space allocator: tracks the ring bookkeeping, predicts every
// result and compares it with what the block returns.
module nrsa_ring_checker
  import nrsa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  mode_i,
  input  logic [17:0] move_length_i,
  input  logic [16:0] max_recv_length_i,
  input  logic [16:0] bytes_received_i,
  input  logic [16:0] release_size_i,
  input  logic [16:0] request_size_i,
  // Size register write
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [16:0] cfg_data_i,
  // Result channel
  input  logic        done_i,
  input  logic        granted_i,
  input  logic [16:0] start_offset_i,
  input  logic [16:0] send_length_i,
  input  logic        copy_valid_i,
  input  logic [16:0] copy_from_i,
  input  logic [16:0] copy_length_i,
  input  logic [16:0] used_bytes_i,
  input  logic [31:0] total_bytes_i,
  input  logic [16:0] write_offset_now_i,
  output int          mismatch_count_o,
  output int          pending_o
);

  // Predicted ring bookkeeping
  int                ring_bytes;
  logic [OffW-1:0]   wr_off;
  logic [OffW-1:0]   rd_off;
  logic [OffW-1:0]   wrap_at;
  logic [OffW-1:0]   used;
  logic [TotalW-1:0] total;

  nrsa_result_t due_results[$];
  int           mismatches = 0;

  assign mismatch_count_o = mismatches;

  // Written size to bytes in use: zero means one byte, anything past the top is capped
  function automatic int clamp_ring(input logic [OffW-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > int'(MaxBytes)) return int'(MaxBytes);
    return int'(v);
  endfunction

  task automatic clear_ring(input logic [OffW-1:0] size_w);
    ring_bytes = clamp_ring(size_w);
    wr_off     = '0;
    rd_off     = '0;
    wrap_at    = OffW'(ring_bytes);
    used       = '0;
    total      = '0;
  endtask

  // Apply one request to the ring and work out the result it gives
  task automatic advance_ring(input nrsa_item_t it, output nrsa_result_t res);
    int m, r, b, rel, req;
    int w, u, rd, wm, fin, want, avail, n;
    bit ok, wrapped;
    m   = int'($signed(it.move_length));
    r   = int'(it.max_recv_length);
    b   = int'(it.bytes_received);
    rel = int'(it.release_size);
    req = int'(it.request_size);
    w   = int'(wr_off);
    u   = int'(used);
    rd  = int'(rd_off);
    wm  = int'(wrap_at);
    res = '0;
    case (it.mode)
      MODE_RESERVE: begin
        if (m >= 0 && u + m <= ring_bytes) begin
          if (ring_bytes - w >= m) begin
            res.start_offset = OffW'(w);
            w = w + m;
          end else begin
            // tail too short: restart at the front, old data ends at the mark
            wm = w;
            res.start_offset = '0;
            w = m;
          end
          u = u + m;
          total = total + TotalW'(m);
          res.granted = 1'b1;
        end
      end
      MODE_RECV_MOVE: begin
        fin = w + m;
        ok = (u + m + r <= ring_bytes) && (u + m >= 0) && (fin >= 0);
        wrapped = ok && !(ring_bytes - w >= m + r);
        // partial packet must lie inside the ring to be copied
        if (wrapped && (fin > ring_bytes || b > fin)) ok = 1'b0;
        if (ok) begin
          if (!wrapped) begin
            w = fin;
          end else begin
            wm = w;
            res.copy_valid  = 1'b1;
            res.copy_from   = OffW'(fin - b);
            res.copy_length = OffW'(b);
            w = b;
          end
          u = u + m;
          total = total + TotalW'(m);
          res.granted = 1'b1;
          res.start_offset = OffW'(w);
        end
      end
      MODE_RELEASE: begin
        u = (u > rel) ? u - rel : 0;
      end
      MODE_GET_SEND: begin
        // reader caught up with the mark: back to the front
        if (rd >= wm) begin
          wm = ring_bytes;
          rd = 0;
        end
        if (u > 0) begin
          want  = (u > req) ? req : u;
          avail = wm - rd;
          n     = (avail >= want) ? want : avail;
          res.granted      = 1'b1;
          res.start_offset = OffW'(rd);
          res.send_length  = OffW'(n);
          rd = rd + n;
        end
      end
      default: ;
    endcase
    wr_off  = OffW'(w);
    rd_off  = OffW'(rd);
    wrap_at = OffW'(wm);
    used    = OffW'(u);
    res.used_bytes       = used;
    res.total_bytes      = total;
    res.write_offset_now = wr_off;
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s expected %0h got %0h", $time, name, want_v, got_v);
      end
    end
  endtask

  // Follow the three channels: results first, then size writes, then new requests
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    nrsa_result_t exp_r;
    nrsa_item_t   it;
    if (!rst_ni) begin
      clear_ring(ResetBufSize);
      due_results.delete();
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result with nothing expected", $time);
          end
        end else begin
          exp_r = due_results.pop_front();
          check_field("granted", 32'(exp_r.granted), 32'(granted_i));
          check_field("start_offset", 32'(exp_r.start_offset), 32'(start_offset_i));
          check_field("send_length", 32'(exp_r.send_length), 32'(send_length_i));
          check_field("copy_valid", 32'(exp_r.copy_valid), 32'(copy_valid_i));
          check_field("copy_from", 32'(exp_r.copy_from), 32'(copy_from_i));
          check_field("copy_length", 32'(exp_r.copy_length), 32'(copy_length_i));
          check_field("used_bytes", 32'(exp_r.used_bytes), 32'(used_bytes_i));
          check_field("total_bytes", exp_r.total_bytes, total_bytes_i);
          check_field("write_offset_now", 32'(exp_r.write_offset_now),
                      32'(write_offset_now_i));
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        clear_ring(cfg_data_i);
      end
      if (start_i && !busy_i) begin
        it.mode            = mode_i;
        it.move_length     = move_length_i;
        it.max_recv_length = max_recv_length_i;
        it.bytes_received  = bytes_received_i;
        it.release_size    = release_size_i;
        it.request_size    = request_size_i;
        advance_ring(it, exp_r);
        due_results.push_back(exp_r);
      end
      pending_o <= due_results.size();
    end
  end

endmodule

// ===== sim/network_ring_space_allocator_tb.sv =====
// Stimulus and verdict for the ring space allocator
module network_ring_space_allocator_tb;
  import nrsa_pkg::*;

  localparam int WatchdogLimit = 2000;
  localparam int PhaseItems    = 128;

  logic        clk_i             = 1'b0;
  logic        rst_ni            = 1'b0;
  logic        start             = 1'b0;
  logic [1:0]  mode_i            = '0;
  logic [17:0] move_length_i     = '0;
  logic [16:0] max_recv_length_i = '0;
  logic [16:0] bytes_received_i  = '0;
  logic [16:0] release_size_i    = '0;
  logic [16:0] request_size_i    = '0;
  logic        cfg_valid_i       = 1'b0;
  logic [16:0] cfg_data_i        = '0;
  logic        busy;
  logic        cfg_ready_o;
  logic        done_o;
  logic        granted_o;
  logic [16:0] start_offset_o;
  logic [16:0] send_length_o;
  logic        copy_valid_o;
  logic [16:0] copy_from_o;
  logic [16:0] copy_length_o;
  logic [16:0] used_bytes_o;
  logic [31:0] total_bytes_o;
  logic [16:0] write_offset_now_o;

  int mismatch_count;
  int pending_results;
  int sender_idle  = 0;
  int ring_cap     = int'(MaxBytes);
  int quiet_cycles = 0;

  network_ring_space_allocator dut (.*);

  nrsa_ring_checker checker_i (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start_i            (start),
    .busy_i             (busy),
    .mode_i             (mode_i),
    .move_length_i      (move_length_i),
    .max_recv_length_i  (max_recv_length_i),
    .bytes_received_i   (bytes_received_i),
    .release_size_i     (release_size_i),
    .request_size_i     (request_size_i),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_i        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .done_i             (done_o),
    .granted_i          (granted_o),
    .start_offset_i     (start_offset_o),
    .send_length_i      (send_length_o),
    .copy_valid_i       (copy_valid_o),
    .copy_from_i        (copy_from_o),
    .copy_length_i      (copy_length_o),
    .used_bytes_i       (used_bytes_o),
    .total_bytes_i      (total_bytes_o),
    .write_offset_now_i (write_offset_now_o),
    .mismatch_count_o   (mismatch_count),
    .pending_o          (pending_results)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WatchdogLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Present one item, with a random gap in front, and hold it until taken
  task automatic send_item(input nrsa_item_t it);
    while ($urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start             <= 1'b1;
    mode_i            <= it.mode;
    move_length_i     <= it.move_length;
    max_recv_length_i <= it.max_recv_length;
    bytes_received_i  <= it.bytes_received;
    release_size_i    <= it.release_size;
    request_size_i    <= it.request_size;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic put(input nrsa_mode_e md, input int m, input int r, input int b,
                     input int rel, input int req);
    nrsa_item_t it;
    it.mode            = md;
    it.move_length     = MoveW'(m);
    it.max_recv_length = OffW'(r);
    it.bytes_received  = OffW'(b);
    it.release_size    = OffW'(rel);
    it.request_size    = OffW'(req);
    send_item(it);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic wait_ring_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results != 0);
  endtask

  task automatic write_ring_size(input logic [16:0] v);
    wait_ring_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (v == '0) ring_cap = 1;
    else if (int'(v) > int'(MaxBytes)) ring_cap = int'(MaxBytes);
    else ring_cap = int'(v);
  endtask

  // Mostly lengths that fit the ring, now and then the edges or anything at all
  function automatic int pick_span(input int cap);
    int k;
    k = $urandom_range(15);
    if (k < 9) return $urandom_range(0, cap / 3);
    if (k < 13) return $urandom_range(0, cap);
    if (k == 13) return cap;
    if (k == 14) return 0;
    return $urandom_range(0, 131071);
  endfunction

  // Random request, weighted towards sequences that move through the ring
  task automatic random_request();
    nrsa_item_t it;
    int pick;
    pick = $urandom_range(99);
    it.move_length     = MoveW'($urandom);
    it.max_recv_length = OffW'($urandom);
    it.bytes_received  = OffW'($urandom);
    it.release_size    = OffW'($urandom);
    it.request_size    = OffW'($urandom);
    if (pick < 30) begin
      it.mode = MODE_RESERVE;
      if ($urandom_range(9) != 0) it.move_length = MoveW'(pick_span(ring_cap));
    end else if (pick < 55) begin
      it.mode = MODE_RECV_MOVE;
      case ($urandom_range(9))
        7, 8:    it.move_length = MoveW'(-pick_span(ring_cap / 2));
        9:       ;
        default: it.move_length = MoveW'(pick_span(ring_cap / 2));
      endcase
      it.max_recv_length = OffW'(pick_span(ring_cap / 2));
      it.bytes_received  = OffW'(pick_span(ring_cap / 2));
    end else if (pick < 75) begin
      it.mode = MODE_RELEASE;
      it.release_size = OffW'(pick_span(ring_cap));
    end else begin
      it.mode = MODE_GET_SEND;
      it.request_size = OffW'(pick_span(ring_cap));
    end
    send_item(it);
  endtask

  initial begin
    int phase_size[8];
    int idle_level[3];
    phase_size = '{16, 0, 300, 131071, 1, 4096, 65536, 1000};
    idle_level = '{0, 86, 14};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes on the full ring after reset
    put(MODE_RESERVE, 65536, 0, 0, 0, 0);
    put(MODE_GET_SEND, 0, 0, 0, 0, 131071);
    put(MODE_RELEASE, 0, 0, 0, 131071, 0);
    put(MODE_RECV_MOVE, 131071, 131071, 131071, 0, 0);
    put(MODE_RESERVE, -131072, 0, 0, 0, 0);

    // Directed: wraps and refusals on a 64 byte ring
    write_ring_size(17'd64);
    put(MODE_RESERVE, 40, 0, 0, 0, 0);
    put(MODE_RESERVE, 30, 0, 0, 0, 0);     // too large
    put(MODE_GET_SEND, 0, 0, 0, 0, 100);
    put(MODE_RELEASE, 0, 0, 0, 40, 0);
    put(MODE_GET_SEND, 0, 0, 0, 0, 7);     // nothing to send
    put(MODE_RESERVE, 20, 0, 0, 0, 0);
    put(MODE_RESERVE, 10, 0, 0, 0, 0);     // wraps, sets the mark
    put(MODE_GET_SEND, 0, 0, 0, 0, 100);   // stops at the mark
    put(MODE_GET_SEND, 0, 0, 0, 0, 5);     // reader wraps to the front
    put(MODE_RELEASE, 0, 0, 0, 200, 0);    // saturates at zero
    put(MODE_RECV_MOVE, 20, 10, 0, 0, 0);
    put(MODE_RECV_MOVE, -5, 0, 0, 0, 0);   // shrink
    put(MODE_RECV_MOVE, -100, 0, 0, 0, 0); // over-shrink
    put(MODE_RECV_MOVE, 30, 60, 0, 0, 0);  // no room for the next receive
    put(MODE_RECV_MOVE, 30, 15, 10, 0, 0); // wrap with copy to the front
    put(MODE_RELEASE, 0, 0, 0, 200, 0);
    put(MODE_RECV_MOVE, 50, 0, 0, 0, 0);
    put(MODE_RELEASE, 0, 0, 0, 200, 0);
    put(MODE_RECV_MOVE, 10, 0, 0, 0, 0);   // copy would run past the ring
    put(MODE_RECV_MOVE, 2, 10, 63, 0, 0);  // partial packet longer than the move end
    put(MODE_RESERVE, 5, 0, 0, 0, 0);
    put(MODE_GET_SEND, 0, 0, 0, 0, 0);     // empty span

    // Random phases over several ring sizes and sender gap levels
    for (int p = 0; p < 8; p++) begin
      write_ring_size(17'(phase_size[p]));
      sender_idle = idle_level[p % 3];
      repeat (PhaseItems) random_request();
    end

    wait_ring_idle();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/nrsa_pkg.sv
hdl/nrsa_in_stage.sv
hdl/nrsa_step.sv
hdl/network_ring_space_allocator.sv
sim/nrsa_ring_checker.sv
sim/network_ring_space_allocator_tb.sv
